// ----- rtl/core/hlv_pkg.sv -----
package hlv_pkg;

    // store geometry
    localparam int MaxRhos    = 256;
    localparam int MaxThetas  = 256;
    localparam int BinWidth   = 32;
    localparam int RhoW       = $clog2(MaxRhos);
    localparam int ThetaW     = $clog2(MaxThetas);
    localparam int AddrW      = RhoW + ThetaW;
    localparam int FifoDepth  = 2;

    // configuration register indexes
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_UNIT      = 3'd1;
    localparam logic [2:0] CFG_FIRST_DEG = 3'd2;
    localparam logic [2:0] CFG_STEP_DEG  = 3'd3;
    localparam logic [2:0] CFG_THETAS    = 3'd4;
    localparam logic [2:0] CFG_RHOS      = 3'd5;
    localparam logic [2:0] CFG_ORIGIN    = 3'd6;
    localparam logic [2:0] CFG_SCALE     = 3'd7;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_VOTE  = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_VOTE  = 2'd1,
        CMD_READ  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [14:0]        vote_threshold;
        logic               unit_votes;
        logic [8:0]         first_theta_deg;
        logic [6:0]         theta_step_deg;
        logic [8:0]         theta_count;
        logic [8:0]         rho_count;
        logic signed [19:0] rho_origin;
        logic [23:0]        rho_scale;
    } t_cfg;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic [15:0]        weight;
        logic [RhoW-1:0]    rho;
        logic [ThetaW-1:0]  theta;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TRIG,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_INDEX,
        ST_FETCH,
        ST_UPDATE,
        ST_READ,
        ST_REPLY
    } t_state;

    // round(16384 * sin(d)) for d = 0..90
    localparam logic [14:0] QUARTER_SINE [0:90] = '{
            0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
         2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
         5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
         8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    // sine in q1.14 for an angle already below 360
    function automatic logic signed [15:0] sin_q14(input logic [8:0] d);
        logic [8:0]  ix;
        logic        neg;
        logic [15:0] mag;
        if (d <= 9'd90) begin
            ix = d;
            neg = 1'b0;
        end else if (d <= 9'd180) begin
            ix = 9'd180 - d;
            neg = 1'b0;
        end else if (d <= 9'd270) begin
            ix = d - 9'd180;
            neg = 1'b1;
        end else begin
            ix = 9'd360 - d;
            neg = 1'b1;
        end
        mag = {1'b0, QUARTER_SINE[ix[6:0]]};
        return neg ? $signed(-mag) : $signed(mag);
    endfunction

endpackage

// ----- rtl/core/hlv_in_if.sv -----
interface hlv_in_if;
    import hlv_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] pixel_value;
    logic [7:0]         read_rho_index;
    logic [7:0]         read_theta_index;

    modport source (output valid, mode, x_coord, y_coord, pixel_value,
                    read_rho_index, read_theta_index, input ready);
    modport sink   (input valid, mode, x_coord, y_coord, pixel_value,
                    read_rho_index, read_theta_index, output ready);
endinterface

// ----- rtl/core/hlv_out_if.sv -----
interface hlv_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] bin_count;
    logic        votes_dropped;

    modport source (output valid, bin_count, votes_dropped, input ready);
    modport sink   (input valid, bin_count, votes_dropped, output ready);
endinterface

// ----- rtl/core/hough_line_vote_accumulator.sv -----
// Hough line vote accumulator over a 256 x 256 store of 32-bit bins.
// Input channel i_in takes clear, vote and read words; output channel o_out
// returns one word (bin count and sticky drop flag) for each read word.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user writes it only while the block is idle, which the block does not enforce.
// A front stage accepts and classifies words into a two-entry command
// queue; votes at or under threshold and unused modes are dropped there at once.
// A back sequencer runs the commands. A vote handles each theta bin in turn
// through one trig lookup, one product pair, one add, one scale multiply,
// one index step and a read-modify-write of the single-port bin memory;
// a theta whose rho falls out of range skips the memory.
// A clear walks all 65536 bins of the memory one bin per cycle.
// A read passes the READ and REPLY states to a registered result.
// After reset the same clearing pass runs; words are queued
// meanwhile and configuration writes are taken as usual.
// When the receiver stalls, the result stays in the output register; the
// back keeps working until the next read result needs that register.
module hough_line_vote_accumulator
    import hlv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    hlv_in_if.sink      i_in,
    hlv_out_if.source   o_out
);
    t_cfg r_cfg;
    t_cmd push_cmd, pop_cmd;
    logic push, pop, full, empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vote_threshold  <= 15'd0;
            r_cfg.unit_votes      <= 1'b1;
            r_cfg.first_theta_deg <= 9'd0;
            r_cfg.theta_step_deg  <= 7'd1;
            r_cfg.theta_count     <= 9'd180;
            r_cfg.rho_count       <= 9'd256;
            r_cfg.rho_origin      <= 20'sd0;
            r_cfg.rho_scale       <= 24'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_cfg.vote_threshold  <= i_cfg_data[14:0];
                CFG_UNIT:      r_cfg.unit_votes      <= i_cfg_data[0];
                CFG_FIRST_DEG: r_cfg.first_theta_deg <= i_cfg_data[8:0];
                CFG_STEP_DEG:  r_cfg.theta_step_deg  <= i_cfg_data[6:0];
                CFG_THETAS:    r_cfg.theta_count     <= i_cfg_data[8:0];
                CFG_RHOS:      r_cfg.rho_count       <= i_cfg_data[8:0];
                CFG_ORIGIN:    r_cfg.rho_origin      <= $signed(i_cfg_data[19:0]);
                CFG_SCALE:     r_cfg.rho_scale       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hlv_front u_front (
        .i_cfg  (r_cfg),
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    hlv_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (pop_cmd)
    );

    hlv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_cmd   (pop_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );
endmodule

// ----- rtl/core/hlv_fifo.sv -----
module hlv_fifo
    import hlv_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);
    localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;

    t_cmd            r_mem [FifoDepth];
    logic [PtrW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [PtrW:0]   r_cnt, n_cnt;

    assign o_full  = (r_cnt == (PtrW+1)'(FifoDepth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(FifoDepth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(FifoDepth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

// ----- rtl/core/hlv_front.sv -----
module hlv_front
    import hlv_pkg::*;
(
    input  t_cfg      i_cfg,
    hlv_in_if.sink    i_in,
    input  logic      i_full,
    output logic      o_push,
    output t_cmd      o_cmd
);
    logic [15:0] mag;
    logic        accept;
    logic        votes;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;

    // magnitude of the sample, -32768 maps to 32768
    assign mag   = i_in.pixel_value[15] ? 16'(-i_in.pixel_value) : i_in.pixel_value;
    assign votes = (mag > {1'b0, i_cfg.vote_threshold});

    // classify the word, drop votes at or under threshold and unused modes
    always_comb begin
        o_cmd.x_coord = i_in.x_coord;
        o_cmd.y_coord = i_in.y_coord;
        o_cmd.weight  = i_cfg.unit_votes ? 16'd1 : mag;
        o_cmd.rho     = i_in.read_rho_index;
        o_cmd.theta   = i_in.read_theta_index;
        o_cmd.kind    = CMD_CLEAR;
        o_push        = 1'b0;
        case (t_mode'(i_in.mode))
            MODE_CLEAR: begin
                o_cmd.kind = CMD_CLEAR;
                o_push     = accept;
            end
            MODE_VOTE: begin
                o_cmd.kind = CMD_VOTE;
                o_push     = accept && votes;
            end
            MODE_READ: begin
                o_cmd.kind = CMD_READ;
                o_push     = accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end
endmodule

// ----- rtl/core/hlv_back.sv -----
module hlv_back
    import hlv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    hlv_out_if.source  o_out
);
    localparam logic signed [59:0] RoundHalf = 60'sd1 <<< 33;

    // vote store
    logic [BinWidth-1:0] r_mem [1 << AddrW];
    logic [BinWidth-1:0] r_rdata;

    t_state               r_state, n_state;
    logic [AddrW-1:0]     r_addr, n_addr;
    logic                 r_drop, n_drop;
    logic [8:0]           r_t, n_t;
    logic [8:0]           r_deg, n_deg;
    logic signed [15:0]   r_x, n_x, r_y, n_y;
    logic [15:0]          r_w, n_w;
    logic signed [15:0]   r_cos, n_cos, r_sin, n_sin;
    logic signed [31:0]   r_px, n_px, r_py, n_py;
    logic signed [34:0]   r_diff, n_diff;
    logic signed [41:0]   r_pp_hi, n_pp_hi;
    logic [41:0]          r_pp_lo, n_pp_lo;
    logic                 r_out_valid, n_out_valid;
    logic [BinWidth-1:0]  r_bin, n_bin;
    logic                 r_out_drop, n_out_drop;

    logic                 mem_we;
    logic [BinWidth-1:0]  mem_wdata;
    logic [8:0]           nt, nr, first_deg, deg90, deg_next_raw;
    logic signed [59:0]   p;
    logic [BinWidth:0]    sum;

    assign o_out.valid         = r_out_valid;
    assign o_out.bin_count     = r_bin;
    assign o_out.votes_dropped = r_out_drop;

    // clamped counts and angle helpers
    assign nt           = (i_cfg.theta_count > 9'(MaxThetas)) ? 9'(MaxThetas) : i_cfg.theta_count;
    assign nr           = (i_cfg.rho_count > 9'(MaxRhos)) ? 9'(MaxRhos) : i_cfg.rho_count;
    assign first_deg    = (i_cfg.first_theta_deg >= 9'd360) ?
                          i_cfg.first_theta_deg - 9'd360 : i_cfg.first_theta_deg;
    assign deg90        = (r_deg >= 9'd270) ? r_deg - 9'd270 : r_deg + 9'd90;
    assign deg_next_raw = r_deg + 9'({2'b0, i_cfg.theta_step_deg});

    // rounded bin position with ties upward
    assign p   = (60'(r_pp_hi) <<< 18) + $signed(60'(r_pp_lo)) + RoundHalf;
    assign sum = {1'b0, r_rdata} + (BinWidth+1)'(r_w);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_drop      = r_drop;
        n_t         = r_t;
        n_deg       = r_deg;
        n_x         = r_x;
        n_y         = r_y;
        n_w         = r_w;
        n_cos       = r_cos;
        n_sin       = r_sin;
        n_px        = r_px;
        n_py        = r_py;
        n_diff      = r_diff;
        n_pp_hi     = r_pp_hi;
        n_pp_lo     = r_pp_lo;
        n_out_valid = r_out_valid && !o_out.ready;
        n_bin       = r_bin;
        n_out_drop  = r_out_drop;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                n_drop = 1'b0;
                n_addr = r_addr + 1'b1;
                if (r_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.kind)
                        CMD_CLEAR: begin
                            n_addr  = '0;
                            n_state = ST_CLEAR;
                        end
                        CMD_VOTE: begin
                            n_x     = i_cmd.x_coord;
                            n_y     = i_cmd.y_coord;
                            n_w     = i_cmd.weight;
                            n_t     = '0;
                            n_deg   = first_deg;
                            n_state = (nt == '0) ? ST_IDLE : ST_TRIG;
                        end
                        CMD_READ: begin
                            n_addr  = {i_cmd.rho, i_cmd.theta};
                            n_state = ST_READ;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TRIG: begin
                n_cos   = sin_q14(deg90);
                n_sin   = sin_q14(r_deg);
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_px    = r_x * r_cos;
                n_py    = r_y * r_sin;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_diff  = 35'(r_px) + 35'(r_py) - (35'(i_cfg.rho_origin) <<< 14);
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_pp_hi = $signed(r_diff[34:18]) * $signed({1'b0, i_cfg.rho_scale});
                n_pp_lo = 42'(r_diff[17:0]) * 42'(i_cfg.rho_scale);
                n_state = ST_INDEX;
            end
            ST_INDEX: begin
                if (p[59] || (p[59:34] >= 26'(nr))) begin
                    n_drop = 1'b1;
                    n_t    = r_t + 1'b1;
                    n_deg  = (deg_next_raw >= 9'd360) ? deg_next_raw - 9'd360 : deg_next_raw;
                    n_state = (r_t + 1'b1 >= nt) ? ST_IDLE : ST_TRIG;
                end else begin
                    n_addr  = {p[34 +: RhoW], r_t[ThetaW-1:0]};
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                mem_we    = 1'b1;
                mem_wdata = sum[BinWidth] ? '1 : sum[BinWidth-1:0];
                n_t       = r_t + 1'b1;
                n_deg     = (deg_next_raw >= 9'd360) ? deg_next_raw - 9'd360 : deg_next_raw;
                n_state   = (r_t + 1'b1 >= nt) ? ST_IDLE : ST_TRIG;
            end
            ST_READ: begin
                n_state = ST_REPLY;
            end
            ST_REPLY: begin
                if (!n_out_valid) begin
                    n_out_valid = 1'b1;
                    n_bin       = r_rdata;
                    n_out_drop  = r_drop;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
            r_t         <= '0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
            r_t         <= n_t;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_deg      <= n_deg;
        r_x        <= n_x;
        r_y        <= n_y;
        r_w        <= n_w;
        r_cos      <= n_cos;
        r_sin      <= n_sin;
        r_px       <= n_px;
        r_py       <= n_py;
        r_diff     <= n_diff;
        r_pp_hi    <= n_pp_hi;
        r_pp_lo    <= n_pp_lo;
        r_bin      <= n_bin;
        r_out_drop <= n_out_drop;
    end

    // bin memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_addr];
    end
endmodule
